// ----- rtl/pcrl_pkg.sv -----
`default_nettype none
package pcrl_pkg;
    localparam int NUM_COMMANDS = 64;
    localparam int IDX_W = $clog2(NUM_COMMANDS);

    localparam logic [2:0] CMD_CHECK  = 3'd0;
    localparam logic [2:0] CMD_RECORD = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_TIME   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [2:0] REG_FIRST = 3'd0;
    localparam logic [2:0] REG_LAST  = 3'd1;
    localparam logic [2:0] REG_WIN   = 3'd2;
    localparam logic [2:0] REG_LIMIT = 3'd3;
    localparam logic [2:0] REG_RATIO = 3'd4;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_FAILURES = 32'd10;
    localparam logic [6:0]  PERCENT = 7'd100;

    // Division spans the 39-bit dividend 100*failures, one quotient bit a step
    localparam int DIV_STEPS = 39;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] wstart;
        logic [31:0] wreq;
        logic [31:0] wfail;
        logic [6:0]  wratio;
        logic [31:0] preq;
        logic [6:0]  pratio;
        logic [31:0] treq;
        logic [31:0] tfail;
    } entry_t;

    typedef struct packed {
        logic       load;      // capture input beat and start lookup
        logic       rd;        // read entry from table
        logic       exec;      // compute update from entry
        logic       div_start;
        logic       finish;    // apply ratio, write entry, register result
    } ctl_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

// ----- rtl/per_command_rate_limiter.sv -----
`default_nettype none
// An input beat steps through load, read, update and finish; a recorded failure of a
// known command adds the 39-step ratio division in the bit-serial divider. One item in
// flight; the next input beat is taken the cycle after the result is registered.
// A stalled result holds the next item in its final step.
// Reset (asynchronous, rst_n low) restores register defaults, clears stored
// time and marks every table entry as zero through per-entry valid bits.
module per_command_rate_limiter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [15:0] command_id,
    input  wire logic [31:0] now_time,
    input  wire logic        failed,
    input  wire logic [1:0]  new_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             command_known,
    output logic [31:0]      total_requests,
    output logic [31:0]      peak_requests,
    output logic [31:0]      current_requests,
    output logic [31:0]      total_failures,
    output logic [6:0]       peak_fail_ratio,
    output logic [6:0]       current_fail_ratio
);
    import pcrl_pkg::*;

    logic [15:0] first_reg, last_reg, win_reg;
    logic [31:0] limit_reg;
    logic [6:0]  ratio_reg;
    ctl_t ctl;
    sts_t sts;
    logic busy, in_fire, out_free;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_free = !out_valid || !out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            last_reg  <= '0;
            win_reg   <= 16'd30;
            limit_reg <= 32'd60000;
            ratio_reg <= 7'd80;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FIRST: first_reg <= cfg_data[15:0];
                    REG_LAST:  last_reg  <= cfg_data[15:0];
                    REG_WIN:   win_reg   <= cfg_data[15:0];
                    REG_LIMIT: limit_reg <= cfg_data;
                    REG_RATIO: ratio_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (ctl.finish)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    pcrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .ctl      (ctl),
        .busy     (busy)
    );

    pcrl_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .cmd                (cmd),
        .command_id         (command_id),
        .now_time           (now_time),
        .failed             (failed),
        .new_status         (new_status),
        .first_command      (first_reg),
        .last_command       (last_reg),
        .window_seconds     (win_reg),
        .request_limit      (limit_reg),
        .fail_ratio_limit   (ratio_reg),
        .status             (status),
        .command_known      (command_known),
        .total_requests     (total_requests),
        .peak_requests      (peak_requests),
        .current_requests   (current_requests),
        .total_failures     (total_failures),
        .peak_fail_ratio    (peak_fail_ratio),
        .current_fail_ratio (current_fail_ratio)
    );
endmodule
`default_nettype wire

// ----- rtl/pcrl_ctrl.sv -----
`default_nettype none
module pcrl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_free,
    input  wire pcrl_pkg::sts_t sts,
    output pcrl_pkg::ctl_t     ctl,
    output logic               busy
);
    import pcrl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctl.rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ----- rtl/pcrl_div.sv -----
`default_nettype none
module pcrl_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [38:0] dividend,
    input  wire logic [31:0] divisor,
    output logic [38:0]      quotient,
    output logic             done
);
    import pcrl_pkg::*;

    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [31:0] rem_reg;
    logic [38:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    assign trial = {rem_reg, quo_reg[38]};
    assign diff  = {1'b0, trial} - {2'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'(DIV_STEPS - 1);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
                run_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[37:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[37:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done = run_reg && (cnt_reg == '0);
endmodule
`default_nettype wire

// ----- rtl/pcrl_dp.sv -----
`default_nettype none
module pcrl_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcrl_pkg::ctl_t ctl,
    output pcrl_pkg::sts_t      sts,
    input  wire logic [2:0]     cmd,
    input  wire logic [15:0]    command_id,
    input  wire logic [31:0]    now_time,
    input  wire logic           failed,
    input  wire logic [1:0]     new_status,
    input  wire logic [15:0]    first_command,
    input  wire logic [15:0]    last_command,
    input  wire logic [15:0]    window_seconds,
    input  wire logic [31:0]    request_limit,
    input  wire logic [6:0]     fail_ratio_limit,
    output logic [1:0]          status,
    output logic                command_known,
    output logic [31:0]         total_requests,
    output logic [31:0]         peak_requests,
    output logic [31:0]         current_requests,
    output logic [31:0]         total_failures,
    output logic [6:0]          peak_fail_ratio,
    output logic [6:0]          current_fail_ratio
);
    import pcrl_pkg::*;

    entry_t mem [NUM_COMMANDS];
    logic [NUM_COMMANDS-1:0] valid_reg;

    logic [2:0]       cmd_reg;
    logic             fail_reg;
    logic [1:0]       ns_reg;
    logic             known_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      time_reg;
    entry_t           rd_reg;
    logic             rd_valid_reg;
    entry_t           upd_reg;
    logic             chk_ratio_reg;

    entry_t cur, upd;
    logic   known;
    logic [15:0] off;
    logic [31:0] elapsed;
    logic [31:0] time_eff;
    logic        need_div;
    logic [38:0] quotient;
    logic        div_done;
    logic [6:0]  ratio;
    entry_t      fin;

    assign off = command_id - first_command;
    assign known = (last_command > first_command) && (command_id >= first_command)
                   && (command_id <= last_command) && (off < 16'(NUM_COMMANDS));

    // Invalid entries read as reset value
    assign cur = rd_valid_reg ? rd_reg : '0;
    assign time_eff = time_reg;
    assign elapsed = time_eff - cur.wstart;

    always_comb
    begin
        upd = cur;
        need_div = 1'b0;
        case (cmd_reg)
            CMD_CHECK:
            begin
                if (cur.status == ST_BLOCKED && elapsed > {16'd0, window_seconds})
                begin
                    upd.wstart = time_eff;
                    upd.status = ST_NORMAL;
                    upd.wreq = '0;
                    upd.wfail = '0;
                    upd.wratio = '0;
                end
            end
            CMD_RECORD:
            begin
                if (elapsed >= {16'd0, window_seconds})
                begin
                    upd.wstart = time_eff;
                    if (cur.wreq > cur.preq)
                        upd.preq = cur.wreq;
                    if (cur.wratio > cur.pratio)
                        upd.pratio = cur.wratio;
                    upd.wreq = '0;
                    upd.wfail = '0;
                    upd.wratio = '0;
                end
                else if (cur.wreq >= request_limit)
                begin
                    upd.status = ST_BLOCKED;
                end
                if (cur.treq != MAX32)
                    upd.treq = cur.treq + 32'd1;
                if (upd.wreq != MAX32)
                    upd.wreq = upd.wreq + 32'd1;
                if (fail_reg)
                begin
                    if (cur.tfail != MAX32)
                        upd.tfail = cur.tfail + 32'd1;
                    if (upd.wfail != MAX32)
                        upd.wfail = upd.wfail + 32'd1;
                    need_div = 1'b1;
                end
            end
            CMD_SET:
            begin
                if (ns_reg != ST_INVALID)
                begin
                    upd.status = ns_reg;
                    if (ns_reg == ST_NORMAL)
                    begin
                        upd.wreq = '0;
                        upd.wfail = '0;
                        upd.wratio = '0;
                    end
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    assign sts.need_div = need_div && known_reg;
    assign sts.div_done = div_done;

    // 100*x as (x<<6)+(x<<5)+(x<<2)
    pcrl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend ({1'b0, upd.wfail, 6'd0} + {2'b0, upd.wfail, 5'd0}
                   + {5'b0, upd.wfail, 2'd0}),
        .divisor  (upd.wreq),
        .quotient (quotient),
        .done     (div_done)
    );

    assign ratio = (quotient > 39'(PERCENT)) ? PERCENT : quotient[6:0];

    always_comb
    begin
        fin = upd_reg;
        if (chk_ratio_reg)
        begin
            fin.wratio = ratio;
            if (ratio > fail_ratio_limit && upd_reg.wfail > MIN_FAILURES)
                fin.status = ST_BLOCKED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            fail_reg  <= failed;
            ns_reg    <= new_status;
            known_reg <= known;
            idx_reg   <= off[IDX_W-1:0];
        end
        if (ctl.rd)
        begin
            rd_reg <= mem[idx_reg];
            rd_valid_reg <= valid_reg[idx_reg];
        end
        if (ctl.exec)
        begin
            upd_reg <= upd;
            chk_ratio_reg <= need_div;
        end
        if (ctl.finish && known_reg)
            mem[idx_reg] <= fin;
        if (ctl.finish)
        begin
            status <= known_reg ? fin.status : ST_NORMAL;
            command_known <= known_reg;
            if (known_reg && cmd_reg == CMD_READ)
            begin
                total_requests     <= fin.treq;
                peak_requests      <= fin.preq;
                current_requests   <= fin.wreq;
                total_failures     <= fin.tfail;
                peak_fail_ratio    <= fin.pratio;
                current_fail_ratio <= fin.wratio;
            end
            else
            begin
                total_requests     <= '0;
                peak_requests      <= '0;
                current_requests   <= '0;
                total_failures     <= '0;
                peak_fail_ratio    <= '0;
                current_fail_ratio <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            time_reg  <= '0;
        end
        else
        begin
            if (ctl.load && (cmd == CMD_CHECK || cmd == CMD_TIME))
                time_reg <= now_time;
            if (ctl.finish && known_reg)
                valid_reg[idx_reg] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
    import pcrl_pkg::*;

    localparam logic [2:0] CMD_SPARE = 3'd5;
    localparam logic [2:0] CMD_SPARE_TOP = 3'd7;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        known;
        logic [31:0] treq;
        logic [31:0] preq;
        logic [31:0] creq;
        logic [31:0] tfail;
        logic [6:0]  pratio;
        logic [6:0]  cratio;
    } stats_t;

    class limiter_scoreboard;
        logic [15:0] first_cmd;
        logic [15:0] last_cmd;
        logic [15:0] win_len;
        logic [31:0] req_limit;
        logic [6:0]  ratio_limit;
        logic [31:0] clock_now;
        entry_t      tbl[NUM_COMMANDS];
        stats_t      pending[$];
        int          mismatches;
        int          results_seen;

        function new();
            first_cmd = 0;
            last_cmd = 0;
            win_len = 30;
            req_limit = 60000;
            ratio_limit = 80;
            clock_now = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (tbl[i]) tbl[i] = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_FIRST: first_cmd = val[15:0];
                REG_LAST:  last_cmd = val[15:0];
                REG_WIN:   win_len = val[15:0];
                REG_LIMIT: req_limit = val;
                REG_RATIO: ratio_limit = val[6:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == MAX32) ? v : v + 32'd1;
        endfunction

        function void note_input(logic [2:0] op, logic [15:0] id, logic [31:0] now,
                                 logic fail, logic [1:0] ns);
            stats_t r;
            int e;
            logic known;
            logic [63:0] q;
            r = '0;
            e = 0;
            known = 0;
            if (last_cmd > first_cmd && id >= first_cmd && id <= last_cmd
                && (id - first_cmd) < NUM_COMMANDS)
            begin
                known = 1;
                e = id - first_cmd;
            end
            if (op == CMD_CHECK || op == CMD_TIME)
                clock_now = now;
            if (known) begin
                case (op)
                    CMD_CHECK:
                        if (tbl[e].status == ST_BLOCKED
                            && (clock_now - tbl[e].wstart) > {16'd0, win_len})
                        begin
                            tbl[e].wstart = clock_now;
                            tbl[e].status = ST_NORMAL;
                            tbl[e].wreq = 0;
                            tbl[e].wfail = 0;
                            tbl[e].wratio = 0;
                        end
                    CMD_RECORD: begin
                        if ((clock_now - tbl[e].wstart) >= {16'd0, win_len}) begin
                            tbl[e].wstart = clock_now;
                            if (tbl[e].wreq > tbl[e].preq) tbl[e].preq = tbl[e].wreq;
                            if (tbl[e].wratio > tbl[e].pratio)
                                tbl[e].pratio = tbl[e].wratio;
                            tbl[e].wreq = 0;
                            tbl[e].wfail = 0;
                            tbl[e].wratio = 0;
                        end else if (tbl[e].wreq >= req_limit)
                            tbl[e].status = ST_BLOCKED;
                        tbl[e].treq = bump(tbl[e].treq);
                        tbl[e].wreq = bump(tbl[e].wreq);
                        if (fail) begin
                            tbl[e].tfail = bump(tbl[e].tfail);
                            tbl[e].wfail = bump(tbl[e].wfail);
                            q = (64'd100 * tbl[e].wfail) / tbl[e].wreq;
                            if (q > 100) q = 100;
                            tbl[e].wratio = q[6:0];
                            if (tbl[e].wratio > ratio_limit && tbl[e].wfail > MIN_FAILURES)
                                tbl[e].status = ST_BLOCKED;
                        end
                    end
                    CMD_SET:
                        if (ns != ST_INVALID) begin
                            tbl[e].status = ns;
                            if (ns == ST_NORMAL) begin
                                tbl[e].wreq = 0;
                                tbl[e].wfail = 0;
                                tbl[e].wratio = 0;
                            end
                        end
                    CMD_READ: begin
                        r.treq = tbl[e].treq;
                        r.preq = tbl[e].preq;
                        r.creq = tbl[e].wreq;
                        r.tfail = tbl[e].tfail;
                        r.pratio = tbl[e].pratio;
                        r.cratio = tbl[e].wratio;
                    end
                    default: ;
                endcase
                r.status = tbl[e].status;
                r.known = 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(stats_t got);
            stats_t exp_r;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at result %0d: expected %p got %p",
                             results_seen, exp_r, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  cmd = 0;
    logic [15:0] command_id = 0;
    logic [31:0] now_time = 0;
    logic        failed = 0;
    logic [1:0]  new_status = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status;
    logic        command_known;
    logic [31:0] total_requests, peak_requests, current_requests, total_failures;
    logic [6:0]  peak_fail_ratio, current_fail_ratio;

    per_command_rate_limiter uut (.*);

    always #2 clk = ~clk;

    limiter_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycles = 0;
    int  items_sent = 0;
    logic [31:0] sim_clock = 1000;

    localparam int LIMIT = 2_000_000;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("per_command_rate_limiter test failed");
            $finish;
        end
    end

    // receiver: sample accepted beats, then redraw the stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, command_known, total_requests, peak_requests,
                             current_requests, total_failures, peak_fail_ratio,
                             current_fail_ratio});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // valid stays high after the beat; the next call or drain decides what follows
    task automatic send_item(logic [2:0] op, logic [15:0] id, logic [31:0] now,
                             logic fail, logic [1:0] ns);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        cmd <= op;
        command_id <= id;
        now_time <= now;
        failed <= fail;
        new_status <= ns;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(op, id, now, fail, ns);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_table(logic [15:0] f, logic [15:0] l, logic [15:0] w,
                             logic [31:0] lim, logic [6:0] rl);
        drain();
        write_reg(REG_FIRST, {16'd0, f});
        write_reg(REG_LAST, {16'd0, l});
        write_reg(REG_WIN, {16'd0, w});
        write_reg(REG_LIMIT, lim);
        write_reg(REG_RATIO, {25'd0, rl});
        cfg_valid <= 0;
    endtask

    // mostly ids inside the table, some just outside and some anywhere
    function automatic logic [15:0] pick_id();
        int k;
        k = $urandom_range(99);
        if (k < 80) return 16'(sb.first_cmd + $urandom_range(NUM_COMMANDS + 1));
        if (k < 90) return 16'(sb.first_cmd - 16'd1);
        return 16'($urandom);
    endfunction

    task automatic random_phase(int n);
        int k;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 50) op = CMD_RECORD;
            else if (k < 62) op = CMD_CHECK;
            else if (k < 70) op = CMD_TIME;
            else if (k < 78) op = CMD_SET;
            else if (k < 97) op = CMD_READ;
            else op = 3'($urandom_range(7, 5));
            // advance time slowly so windows roll now and then
            if ($urandom_range(9) == 0) sim_clock = sim_clock + 32'($urandom_range(40));
            if ($urandom_range(49) == 0) sim_clock = 32'($urandom);
            send_item(op, pick_id(), sim_clock, $urandom_range(99) < 70,
                      2'($urandom_range(3)));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // table inactive after reset
        send_item(CMD_RECORD, 16'd0, 0, 1, ST_NORMAL);
        send_item(CMD_READ, 16'd0, 0, 0, ST_NORMAL);
        send_item(CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 0, ST_NORMAL);

        set_table(16'd100, 16'd300, 16'd5, 32'd3, 7'd50);
        send_item(CMD_TIME, 16'd100, 32'd10, 0, ST_NORMAL);
        for (int i = 0; i < 14; i++) send_item(CMD_RECORD, 16'd163, 0, 1, ST_NORMAL);
        send_item(CMD_READ, 16'd163, 0, 0, ST_NORMAL);
        send_item(CMD_READ, 16'd164, 0, 0, ST_NORMAL);   // beyond table depth
        send_item(CMD_READ, 16'd99, 0, 0, ST_NORMAL);
        send_item(CMD_CHECK, 16'd163, 32'd16, 0, ST_NORMAL);
        send_item(CMD_RECORD, 16'd163, 0, 0, ST_NORMAL);
        send_item(CMD_SET, 16'd100, 0, 0, ST_INVALID);
        send_item(CMD_SET, 16'd100, 0, 0, ST_STOPPED);
        send_item(CMD_SET, 16'd163, 0, 0, ST_NORMAL);
        send_item(CMD_SPARE, 16'd100, 0, 0, ST_NORMAL);
        send_item(CMD_SPARE_TOP, 16'd163, 0, 0, ST_NORMAL);
        send_item(CMD_READ, 16'd163, 0, 0, ST_NORMAL);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case (ph)
                0: set_table(16'd0, 16'd63, 16'd30, 32'd60000, 7'd80);
                1: set_table(16'd1000, 16'd1020, 16'd0, 32'd0, 7'd0);
                2: set_table(16'hFFC0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'd100);
                3: set_table(16'd500, 16'd500, 16'd10, 32'd5, 7'd20);
                4: set_table(16'd7, 16'd2000, 16'd3, 32'd4, 7'd127);
                5: set_table(16'($urandom), 16'hFFFF, 16'($urandom_range(60)),
                             32'($urandom_range(20)), 7'($urandom_range(100)));
                6: set_table(16'd20, 16'd10, 16'd8, 32'd2, 7'd60);
                default: set_table(16'd0, 16'd1, 16'd12, 32'd8, 7'd90);
            endcase
            random_phase(155);
        end
        drain();
        $display("%0d items sent, %0d results checked over 8 register settings",
                 items_sent, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("per_command_rate_limiter test passed");
        else
            $display("per_command_rate_limiter test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- per_command_rate_limiter.f -----
rtl/pcrl_pkg.sv
rtl/pcrl_ctrl.sv
rtl/pcrl_div.sv
rtl/pcrl_dp.sv
rtl/per_command_rate_limiter.sv
tb/tb_top.sv
